>>> design/wsfd_pkg.sv
// shared types and codes for the websocket frame deframer
package wsfd_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LEN     = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_TOOBIG = 2'd2
    } kind_t;

    // length field codes of the second header byte
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

endpackage

>>> design/websocket_frame_deframer.sv
// websocket frame deframer: byte stream in, unmasked payload transactions out
//
// Usage: received bytes enter on the s_axis channel, one per transaction, with
// s_axis_tuser high to mark a dropped link (the byte is then ignored and the
// parser goes back to waiting for a frame header). Results leave on m_axis:
// tuser holds the kind (payload byte, empty frame, unsupported 64-bit length),
// tdata the unmasked payload byte and the frame opcode, tlast marks the final
// payload byte or the empty-frame result. Header bytes give no result; length
// and key bytes give one only when they end an empty frame or carry the 64-bit
// length code. A taken byte is held in the input register, then the parser
// writes its result into the result register, which presents it on m_axis.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// input and result registers, with the phase update and key xor between them.
// Reset clears the parser to the header phase and empties both registers.
// When the receiver stalls, the result register holds its transaction and the
// input register holds the next byte; s_axis_tready drops only when both are
// full.
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] abort
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [14:8] frame_opcode, [15] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_frame
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_abort_reg;

    // parser state
    wsfd_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       header_bits_reg, header_bits_next;
    logic             has_key_reg, has_key_next;
    logic [15:0]      payload_length_reg, payload_length_next;
    logic [7:0]       key_bytes_reg [4];
    logic             key_we;
    logic [1:0]       key_fill_index_reg, key_fill_index_next;
    logic [15:0]      payload_index_reg, payload_index_next;

    // result register
    logic             out_valid_reg;
    wsfd_pkg::kind_t  out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [6:0]       out_opcode_reg, out_opcode_next;
    logic             out_last_reg, out_last_next;
    logic             emit;

    logic advance;
    logic [6:0]  len_code;
    logic [16:0] index_inc;
    logic        is_last;

    // the parser moves when the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign len_code  = in_byte_reg[6:0];
    assign index_inc = {1'b0, payload_index_reg} + 17'd1;
    assign is_last   = index_inc >= {1'b0, payload_length_reg};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_abort_reg <= s_axis_tuser;
        end
    end

    // phase update and result selection
    always_comb
    begin
        phase_next          = phase_reg;
        header_bits_next    = header_bits_reg;
        has_key_next        = has_key_reg;
        payload_length_next = payload_length_reg;
        key_fill_index_next = key_fill_index_reg;
        payload_index_next  = payload_index_reg;
        key_we              = 1'b0;
        emit                = 1'b0;
        out_kind_next       = wsfd_pkg::KIND_DATA;
        out_byte_next       = 8'd0;
        out_opcode_next     = header_bits_reg;
        out_last_next       = 1'b0;

        if (in_abort_reg)
        begin
            phase_next = wsfd_pkg::PH_HEADER;
        end
        else
        begin
            unique case (phase_reg)
                wsfd_pkg::PH_HEADER:
                begin
                    header_bits_next = in_byte_reg[6:0];
                    phase_next       = wsfd_pkg::PH_LEN;
                end
                wsfd_pkg::PH_LEN:
                begin
                    has_key_next = in_byte_reg[7];
                    if (len_code == wsfd_pkg::LEN_CODE_64)
                    begin
                        phase_next    = wsfd_pkg::PH_HEADER;
                        emit          = 1'b1;
                        out_kind_next = wsfd_pkg::KIND_TOOBIG;
                    end
                    else if (len_code == wsfd_pkg::LEN_CODE_16)
                    begin
                        phase_next = wsfd_pkg::PH_LEN_HI;
                    end
                    else
                    begin
                        payload_length_next = {9'd0, len_code};
                        if (in_byte_reg[7])
                        begin
                            key_fill_index_next = 2'd0;
                            phase_next          = wsfd_pkg::PH_KEY;
                        end
                        else
                        begin
                            payload_index_next = 16'd0;
                            if (len_code == 7'd0)
                            begin
                                phase_next    = wsfd_pkg::PH_HEADER;
                                emit          = 1'b1;
                                out_kind_next = wsfd_pkg::KIND_EMPTY;
                                out_last_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = wsfd_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                wsfd_pkg::PH_LEN_HI:
                begin
                    payload_length_next = {in_byte_reg, 8'd0};
                    phase_next          = wsfd_pkg::PH_LEN_LO;
                end
                wsfd_pkg::PH_LEN_LO:
                begin
                    payload_length_next = {payload_length_reg[15:8],
                                           payload_length_reg[7:0] | in_byte_reg};
                    if (has_key_reg)
                    begin
                        key_fill_index_next = 2'd0;
                        phase_next          = wsfd_pkg::PH_KEY;
                    end
                    else
                    begin
                        payload_index_next = 16'd0;
                        if (payload_length_next == 16'd0)
                        begin
                            phase_next    = wsfd_pkg::PH_HEADER;
                            emit          = 1'b1;
                            out_kind_next = wsfd_pkg::KIND_EMPTY;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsfd_pkg::PH_KEY:
                begin
                    key_we = 1'b1;
                    key_fill_index_next = key_fill_index_reg + 2'd1;
                    if (key_fill_index_reg == 2'd3)
                    begin
                        payload_index_next = 16'd0;
                        if (payload_length_reg == 16'd0)
                        begin
                            phase_next    = wsfd_pkg::PH_HEADER;
                            emit          = 1'b1;
                            out_kind_next = wsfd_pkg::KIND_EMPTY;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = wsfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsfd_pkg::PH_PAYLOAD:
                begin
                    emit          = 1'b1;
                    out_kind_next = wsfd_pkg::KIND_DATA;
                    out_last_next = is_last;
                    out_byte_next = has_key_reg
                                  ? (in_byte_reg ^ key_bytes_reg[payload_index_reg[1:0]])
                                  : in_byte_reg;
                    if (is_last)
                    begin
                        phase_next         = wsfd_pkg::PH_HEADER;
                        payload_index_next = 16'd0;
                    end
                    else
                    begin
                        payload_index_next = index_inc[15:0];
                    end
                end
                default:
                begin
                    phase_next = wsfd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= wsfd_pkg::PH_HEADER;
            header_bits_reg    <= 7'd0;
            has_key_reg        <= 1'b0;
            payload_length_reg <= 16'd0;
            key_fill_index_reg <= 2'd0;
            payload_index_reg  <= 16'd0;
            for (int i = 0; i < 4; i++)
            begin
                key_bytes_reg[i] <= 8'd0;
            end
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            header_bits_reg    <= header_bits_next;
            has_key_reg        <= has_key_next;
            payload_length_reg <= payload_length_next;
            key_fill_index_reg <= key_fill_index_next;
            payload_index_reg  <= payload_index_next;
            if (key_we)
            begin
                key_bytes_reg[key_fill_index_reg] <= in_byte_reg;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_opcode_reg <= out_opcode_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_opcode_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // the key is only read after a masked length byte
    a_key_phase_masked: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_KEY |-> has_key_reg)
        else $error("key phase entered without mask flag");

    // payload phase always has bytes left to deliver
    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsfd_pkg::PH_PAYLOAD |->
            (payload_length_reg != 16'd0) && (payload_index_reg < payload_length_reg))
        else $error("payload index out of frame length");

    // empty frame results always close the frame, length errors never do
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_kind_reg == wsfd_pkg::KIND_EMPTY && out_last_reg)
             || (out_kind_reg == wsfd_pkg::KIND_TOOBIG && !out_last_reg)
             || out_kind_reg == wsfd_pkg::KIND_DATA))
        else $error("result kind and last flag disagree");

    // non-data results carry a zero byte
    a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != wsfd_pkg::KIND_DATA |-> out_byte_reg == 8'd0)
        else $error("non-data result with payload byte set");

    // an aborted byte never yields a result
    a_abort_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_abort_reg |=> !out_valid_reg)
        else $error("result produced by aborted byte");

endmodule
